// ----- rtl/spq_pkg.sv -----
// Package for the stable priority queue.
// Holds the beat types, operation and status codes, and the cell control struct.
// No dependencies.
package spq_pkg;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DEQUEUED  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } spq_status_e;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned PrioPortBits = 8;
  localparam int unsigned OccBits = 5;

  typedef struct packed {
    spq_op_e                       operation;
    logic signed [ValueBits-1:0]   value;
    logic [PrioPortBits-1:0]       priority_req;
  } spq_req_t;

  typedef struct packed {
    spq_status_e                   status;
    logic signed [ValueBits-1:0]   out_value;
    logic [PrioPortBits-1:0]       out_priority;
    logic [OccBits-1:0]            occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic                          enq;
    logic                          deq;
    logic [ValueBits-1:0]          value;
  } spq_ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One cell of the sorted shift chain: holds one entry of the queue.
// Depends on spq_pkg for the control struct.
module spq_cell #(
  parameter int unsigned PW = 8
) (
  input  logic                         clk_i,
  input  spq_pkg::spq_ctl_t            ctl_i,
  input  logic [PW-1:0]                new_prio_i,
  input  logic                         valid_i,
  input  logic                         left_keep_i,
  input  logic [spq_pkg::ValueBits-1:0] left_value_i,
  input  logic [PW-1:0]                left_prio_i,
  input  logic [spq_pkg::ValueBits-1:0] right_value_i,
  input  logic [PW-1:0]                right_prio_i,
  output logic                         keep_o,
  output logic [spq_pkg::ValueBits-1:0] value_o,
  output logic [PW-1:0]                prio_o
);
  import spq_pkg::*;

  logic [ValueBits-1:0] value_q, value_d;
  logic [PW-1:0]        prio_q, prio_d;

  // The entry stays in place when it is at least as urgent as the new one.
  assign keep_o = valid_i && (prio_q <= new_prio_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctl_i.deq) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end else if (ctl_i.enq && !keep_o) begin
      if (left_keep_i) begin
        value_d = ctl_i.value;
        prio_d  = new_prio_i;
      end else begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ----- rtl/stable_priority_queue_top.sv -----
// Top level of the stable priority queue: a row of spq_cell instances, the
// entry count and the result register. Depends on spq_pkg and spq_cell.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   request  | start, busy        | req_i  (spq_req_t)
//   result   | done_o strobe      | rsp_o  (spq_rsp_t)
//
// All cells compare against the new priority in parallel and shift in the same
// edge, so busy stays low and a new beat can be started in every cycle. The
// result appears in the cycle after the start beat, for exactly one cycle.
// Reset clears the entry count; the cell contents are only read below the
// count. The receiver cannot stall the result.
module stable_priority_queue_top #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t req_i,
  output logic              done_o,
  output spq_pkg::spq_rsp_t rsp_o
);
  import spq_pkg::*;

  localparam int unsigned PW = PRIORITY_BITS;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WIDE = (PW > PrioPortBits) ? PW : PrioPortBits;
  localparam int unsigned OW = (CW > OccBits) ? CW : OccBits;

  logic [CW-1:0]  count_q, count_d;
  logic           done_q;
  spq_rsp_t       rsp_q, rsp_d;
  logic           accept;
  logic           full, empty;
  spq_ctl_t       ctl;
  logic [WIDE-1:0] prio_in_wide;
  logic [PW-1:0]  new_prio;
  logic [WIDE-1:0] prio_out_wide;
  logic [OW-1:0]  occ_wide;

  logic [CAPACITY-1:0]                 cell_valid;
  logic [CAPACITY-1:0]                 cell_keep;
  logic [CAPACITY-1:0][ValueBits-1:0]  cell_value;
  logic [CAPACITY-1:0][PW-1:0]         cell_prio;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);

  assign prio_in_wide = WIDE'(req_i.priority_req);
  assign new_prio     = prio_in_wide[PW-1:0];

  assign ctl.enq   = accept && (req_i.operation == OP_ENQUEUE) && !full;
  assign ctl.deq   = accept && (req_i.operation == OP_DEQUEUE) && !empty;
  assign ctl.value = req_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 left_keep;
    logic [ValueBits-1:0] left_value, right_value;
    logic [PW-1:0]        left_prio, right_prio;

    assign cell_valid[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = req_i.value;
      assign left_prio  = new_prio;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PW(PW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .new_prio_i   (new_prio),
      .valid_i      (cell_valid[i]),
      .left_keep_i  (left_keep),
      .left_value_i (left_value),
      .left_prio_i  (left_prio),
      .right_value_i(right_value),
      .right_prio_i (right_prio),
      .keep_o       (cell_keep[i]),
      .value_o      (cell_value[i]),
      .prio_o       (cell_prio[i])
    );
  end

  assign prio_out_wide = WIDE'(cell_prio[0]);

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CW'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CW'(1);
    end
  end

  assign occ_wide = OW'(count_d);

  always_comb begin
    rsp_d              = rsp_q;
    rsp_d.out_value    = '0;
    rsp_d.out_priority = '0;
    rsp_d.occupancy    = occ_wide[OccBits-1:0];
    unique case (req_i.operation)
      OP_ENQUEUE: begin
        rsp_d.status = full ? ST_FULL : ST_ENQUEUED;
      end
      OP_DEQUEUE: begin
        if (empty) begin
          rsp_d.status = ST_UNDERFLOW;
        end else begin
          rsp_d.status       = ST_DEQUEUED;
          rsp_d.out_value    = cell_value[0];
          rsp_d.out_priority = prio_out_wide[PrioPortBits-1:0];
        end
      end
      default: rsp_d.status = ST_UNDERFLOW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted beat");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_UNDERFLOW) |-> ($past(count_q) == '0))
    else $error("underflow reported on a non-empty queue");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count changed without a beat");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full rejection while the store had room");

endmodule

// ----- tb/sv/spq_checker.sv -----
`timescale 1ns / 100ps
// Response checker for the stable priority queue: mirrors the sorted store, predicts
// the response to every accepted request beat and compares it with the result beats.
// Depends on spq_pkg.
module spq_checker #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  spq_pkg::spq_req_t req_i,
  input  logic              done_i,
  input  spq_pkg::spq_rsp_t rsp_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o
);
  import spq_pkg::*;

  localparam logic [PrioPortBits-1:0] PrioMask =
    (PRIORITY_BITS >= PrioPortBits) ? {PrioPortBits{1'b1}} :
    PrioPortBits'((1 << PRIORITY_BITS) - 1);

  logic signed [ValueBits-1:0] mirror_value [CAPACITY];
  logic [PrioPortBits-1:0]     mirror_prio  [CAPACITY];
  int unsigned                 mirror_count;
  spq_rsp_t                    expected_rsps [$];

  function automatic spq_rsp_t apply_to_mirror(spq_req_t r);
    spq_rsp_t rsp;
    int unsigned slot;
    logic [PrioPortBits-1:0] key;
    rsp = '0;
    key = r.priority_req & PrioMask;
    if (r.operation == OP_ENQUEUE) begin
      if (mirror_count >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < mirror_count && mirror_prio[slot] <= key) slot++;
        for (int unsigned k = mirror_count; k > slot; k--) begin
          mirror_value[k] = mirror_value[k-1];
          mirror_prio[k]  = mirror_prio[k-1];
        end
        mirror_value[slot] = r.value;
        mirror_prio[slot]  = key;
        mirror_count++;
        rsp.status = ST_ENQUEUED;
      end
    end else begin
      if (mirror_count == 0) begin
        rsp.status = ST_UNDERFLOW;
      end else begin
        rsp.status       = ST_DEQUEUED;
        rsp.out_value    = mirror_value[0];
        rsp.out_priority = mirror_prio[0];
        for (int unsigned k = 1; k < mirror_count; k++) begin
          mirror_value[k-1] = mirror_value[k];
          mirror_prio[k-1]  = mirror_prio[k];
        end
        mirror_count--;
      end
    end
    rsp.occupancy = OccBits'(mirror_count);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_rsp_t want;
    if (!rst_ni) begin
      mirror_count = 0;
      expected_rsps.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t mismatch: result beat with nothing expected, got %p", $time, rsp_i);
          fail_count_o++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.status !== want.status) begin
            $display("%0t mismatch status: expected %s got %0d",
                     $time, want.status.name(), rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.out_value !== want.out_value) begin
            $display("%0t mismatch out_value: expected %0d got %0d",
                     $time, want.out_value, rsp_i.out_value);
            fail_count_o++;
          end
          if (rsp_i.out_priority !== want.out_priority) begin
            $display("%0t mismatch out_priority: expected %0d got %0d",
                     $time, want.out_priority, rsp_i.out_priority);
            fail_count_o++;
          end
          if (rsp_i.occupancy !== want.occupancy) begin
            $display("%0t mismatch occupancy: expected %0d got %0d",
                     $time, want.occupancy, rsp_i.occupancy);
            fail_count_o++;
          end
        end
      end
      if (start && !busy) expected_rsps.push_back(apply_to_mirror(req_i));
      outstanding_o = expected_rsps.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the stable priority queue testbench: clock, reset, request stimulus and verdict.
// Depends on spq_pkg, stable_priority_queue_top and spq_checker.
module tb_top;
  import spq_pkg::*;

  localparam int unsigned Capacity      = 16;
  localparam int unsigned PriorityBits  = 8;
  localparam int unsigned WatchdogLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  spq_req_t    req_beat;
  logic        done_o;
  spq_rsp_t    rsp_beat;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned idle_cycles;

  stable_priority_queue_top #(
    .CAPACITY     (Capacity),
    .PRIORITY_BITS(PriorityBits)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_beat),
    .done_o(done_o),
    .rsp_o (rsp_beat)
  );

  spq_checker #(
    .CAPACITY     (Capacity),
    .PRIORITY_BITS(PriorityBits)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_beat),
    .done_i       (done_o),
    .rsp_i        (rsp_beat),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input spq_req_t r);
    start    <= 1'b1;
    req_beat <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ValueBits-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(ValueBits-1){1'b0}}};
      1:       return {1'b0, {(ValueBits-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic spq_req_t make_req(spq_op_e op, logic [PrioPortBits-1:0] prio);
    spq_req_t r;
    r.operation    = op;
    r.value        = pick_value();
    r.priority_req = prio;
    return r;
  endfunction

  task automatic run_directed();
    logic [PrioPortBits-1:0] fill_prio [16];
    fill_prio = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd7, 8'd7, 8'd1,
                  8'd254, 8'd128, 8'd0, 8'd200, 8'd7, 8'd255, 8'd1, 8'd64};
    send_beat(make_req(OP_DEQUEUE, 8'd0));
    for (int unsigned i = 0; i < Capacity; i++) begin
      send_beat(make_req(OP_ENQUEUE, fill_prio[i % 16]));
    end
    send_beat(make_req(OP_ENQUEUE, 8'd0));
    send_beat(make_req(OP_ENQUEUE, 8'd255));
    repeat (4) send_beat(make_req(OP_DEQUEUE, 8'hA5));
  endtask

  task automatic run_phase(input int unsigned beats, input int unsigned enq_pct,
                           input bit narrow_prio, input bit back_to_back);
    spq_op_e                 op;
    logic [PrioPortBits-1:0] prio;
    for (int unsigned i = 0; i < beats; i++) begin
      op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      prio = narrow_prio ? PrioPortBits'($urandom_range(0, 3)) : PrioPortBits'($urandom());
      send_beat(make_req(op, prio));
      if (!back_to_back) idle_for(gap_length());
    end
  endtask

  initial begin
    int unsigned enq_mix [5];
    enq_mix     = '{80, 20, 50, 65, 35};
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_beat    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_drained();

    for (int unsigned phase = 0; phase < 15; phase++) begin
      run_phase(95, enq_mix[phase % 5], (phase % 3) == 1, (phase % 4) == 2);
      if ((phase % 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
